/* hw/rtl/tsa_pkg.sv */
package tsa_pkg;

  localparam int CORDIC_ITERS = 18;
  localparam int VEL_W        = 16;
  localparam int ANG_W        = 16;
  localparam int WB_W         = 16;
  localparam int MAXA_W       = 15;
  localparam int PROD_W       = WB_W + VEL_W;
  localparam int XY_W         = 58;
  localparam int Z_W          = 32;
  localparam int X_SHIFT      = 32;
  localparam int Y_SHIFT      = 24;
  localparam int RND_SHIFT    = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 1'b1;

  localparam logic [WB_W-1:0]   WB_RESET    = 16'd256;
  localparam logic [MAXA_W-1:0] MAXA_RESET  = 15'd20016;
  localparam logic [MAXA_W-1:0] HALF_PI_Q14 = 15'd25736;
  localparam logic [Z_W:0]      ROUND_HALF  = 33'd32768;

  localparam logic signed [Z_W-1:0] ATAN_Q30 [CORDIC_ITERS] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
    32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
    32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
    32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF
  };

  typedef struct packed {
    logic [PROD_W-1:0]       prod;
    logic [VEL_W-1:0]        vmag;
    logic                    zero;
    logic                    neg;
    logic signed [VEL_W-1:0] speed;
  } front_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic                    zero;
    logic                    neg;
    logic signed [VEL_W-1:0] speed;
  } cordic_t;

endpackage

/* hw/rtl/tsa_if.sv */
interface tsa_cmd_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  linear_velocity;
  logic signed [15:0]  angular_velocity;

  modport source (output valid, output linear_velocity, output angular_velocity,
                  input ready);
  modport sink (input valid, input linear_velocity, input angular_velocity,
                output ready);
endinterface

interface tsa_res_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  drive_speed;
  logic signed [15:0]  wheel_angle;

  modport source (output valid, output drive_speed, output wheel_angle,
                  input ready);
  modport sink (input valid, input drive_speed, input wheel_angle,
                output ready);
endinterface

/* hw/rtl/tsa_front.sv */
module tsa_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [tsa_pkg::VEL_W-1:0] lin,
  input  logic signed [tsa_pkg::VEL_W-1:0] ang,
  input  logic [tsa_pkg::WB_W-1:0]         wb,
  output logic                             out_valid,
  output tsa_pkg::front_t                  out_data
);
  import tsa_pkg::*;

  logic [VEL_W-1:0] vmag;
  logic [VEL_W-1:0] wmag;

  always_comb begin
    vmag = lin[VEL_W-1] ? VEL_W'(-lin) : VEL_W'(lin);
    wmag = ang[VEL_W-1] ? VEL_W'(-ang) : VEL_W'(ang);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.prod  <= PROD_W'(wb) * PROD_W'(wmag);
      out_data.vmag  <= vmag;
      out_data.zero  <= (vmag == '0) || (wmag == '0) || (wb == '0);
      out_data.neg   <= ang[VEL_W-1];
      out_data.speed <= lin;
    end
  end

endmodule

/* hw/rtl/tsa_cordic_stage.sv */
module tsa_cordic_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  tsa_pkg::cordic_t in_data,
  output logic             out_valid,
  output tsa_pkg::cordic_t out_data
);
  import tsa_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  cordic_t                data_next;

  always_comb begin
    dx        = in_data.y >>> STAGE;
    dy        = in_data.x >>> STAGE;
    data_next = in_data;
    if (in_data.y > 0) begin
      data_next.x = in_data.x + dx;
      data_next.y = in_data.y - dy;
      data_next.z = in_data.z + ATAN_Q30[STAGE];
    end else begin
      data_next.x = in_data.x - dx;
      data_next.y = in_data.y + dy;
      data_next.z = in_data.z - ATAN_Q30[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

/* hw/rtl/tsa_finish.sv */
module tsa_finish (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  tsa_pkg::cordic_t                  in_data,
  input  logic [tsa_pkg::MAXA_W-1:0]        max_angle,
  output logic                              out_valid,
  output logic signed [tsa_pkg::VEL_W-1:0]  speed,
  output logic signed [tsa_pkg::ANG_W-1:0]  angle
);
  import tsa_pkg::*;

  localparam int R_W = Z_W + 1 - RND_SHIFT;

  logic [Z_W:0]        zr;
  logic [R_W-1:0]      rnd;
  logic [MAXA_W-1:0]   mag_q;
  logic [MAXA_W-1:0]   mag;
  logic [ANG_W-1:0]    angle_next;

  always_comb begin
    zr    = in_data.z[Z_W-1] ? '0 : ({1'b0, in_data.z} + ROUND_HALF);
    rnd   = zr[Z_W:RND_SHIFT];
    mag_q = (rnd > R_W'(HALF_PI_Q14)) ? HALF_PI_Q14 : rnd[MAXA_W-1:0];
    mag   = (mag_q > max_angle) ? max_angle : mag_q;
    if (in_data.zero) begin
      mag = '0;
    end
    angle_next = in_data.neg ? -ANG_W'(mag) : ANG_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      speed <= in_data.speed;
      angle <= angle_next;
    end
  end

endmodule

/* hw/rtl/twist_to_steering_angle_top.sv */
// Converts a velocity command into a drive speed and a steering angle. The speed is passed
// through; the angle is atan2(wheelbase * |omega|, |v|) in Q2.14 radians, zero when either
// velocity or the wheelbase is zero, limited to the configured maximum and signed like omega.
// The datapath is a 20-stage pipeline: one multiply stage, 18 vectoring CORDIC iterations,
// and one rounding and limiting stage that is also the output register. A beat can enter on
// every cycle while the output is not stalled. Each stage holds its beat while the
// stage after it is full and stalled, so empty stages still take new commands.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and
// must only change while the pipeline is empty.
module twist_to_steering_angle_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]       cfg_data,
  tsa_cmd_if.sink                              cmd,
  tsa_res_if.source                            res
);
  import tsa_pkg::*;

  localparam int NST = CORDIC_ITERS + 2;

  logic [WB_W-1:0]   wheelbase_length;
  logic [MAXA_W-1:0] max_steering_angle;
  logic [NST-1:0]    vld;
  logic [NST-1:0]    en;
  front_t            front;
  cordic_t           cd [CORDIC_ITERS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase_length   <= WB_RESET;
      max_steering_angle <= MAXA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEELBASE: wheelbase_length   <= cfg_data[WB_W-1:0];
        CFG_MAX_ANGLE: max_steering_angle <= cfg_data[MAXA_W-1:0];
        default:       ;
      endcase
    end
  end

  assign en[NST-1] = !vld[NST-1] || res.ready;

  genvar k;
  generate
    for (k = 0; k < NST - 1; k++) begin : g_en
      assign en[k] = !vld[k] || en[k+1];
    end
  endgenerate

  assign cmd.ready = en[0] && !rst;

  tsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en[0]),
    .in_valid  (cmd.valid && !rst),
    .lin       (cmd.linear_velocity),
    .ang       (cmd.angular_velocity),
    .wb        (wheelbase_length),
    .out_valid (vld[0]),
    .out_data  (front)
  );

  assign cd[0].x     = XY_W'({front.vmag, {X_SHIFT{1'b0}}});
  assign cd[0].y     = XY_W'({front.prod, {Y_SHIFT{1'b0}}});
  assign cd[0].z     = '0;
  assign cd[0].zero  = front.zero;
  assign cd[0].neg   = front.neg;
  assign cd[0].speed = front.speed;

  generate
    for (k = 0; k < CORDIC_ITERS; k++) begin : g_cordic
      tsa_cordic_stage #(
        .STAGE (k)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (en[k+1]),
        .in_valid  (vld[k]),
        .in_data   (cd[k]),
        .out_valid (vld[k+1]),
        .out_data  (cd[k+1])
      );
    end
  endgenerate

  tsa_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en[NST-1]),
    .in_valid  (vld[NST-2]),
    .in_data   (cd[CORDIC_ITERS]),
    .max_angle (max_steering_angle),
    .out_valid (vld[NST-1]),
    .speed     (res.drive_speed),
    .angle     (res.wheel_angle)
  );

  assign res.valid = vld[NST-1];

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> vld[0])
    else $error("Accepted command did not enter the first stage.");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    vld[1] && !en[1] |=> vld[1])
    else $error("Stalled pipeline stage dropped its beat.");

  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.drive_speed == '0) |-> (res.wheel_angle == '0))
    else $error("Nonzero steering angle for zero speed.");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.wheel_angle <= $signed({1'b0, HALF_PI_Q14})) &&
                  (res.wheel_angle >= -$signed({1'b0, HALF_PI_Q14})))
    else $error("Steering angle beyond a quarter turn.");

endmodule
